[src/cefc_pkg.sv]
`timescale 1ns / 1ps
// Package for the cyclic executive frame check: widths, state encoding and the
// command and status groups between controller and datapath. No dependencies.
package cefc_pkg;

  localparam int unsigned PERIOD_BITS = 16;
  localparam int unsigned HYPER_BITS  = 32;
  localparam int unsigned SHIFT_BITS  = $clog2(PERIOD_BITS + 1);
  localparam int unsigned COUNT_BITS  = $clog2(HYPER_BITS + 1);
  localparam int unsigned PROD_BITS   = HYPER_BITS + PERIOD_BITS;

  typedef logic [PERIOD_BITS-1:0] period_t;
  typedef logic [HYPER_BITS-1:0]  hyper_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_GCD_MINOR,
    ST_GCD_LCM,
    ST_DIV,
    ST_CHECK,
    ST_FINISH
  } state_e;

  typedef enum logic {
    GCD_SRC_MINOR,
    GCD_SRC_LCM
  } gcd_src_e;

  typedef struct packed {
    logic     capture;
    logic     init_set;
    logic     fold_wcet;
    logic     gcd_start;
    gcd_src_e gcd_src;
    logic     gcd_step;
    logic     save_minor;
    logic     div_start;
    logic     div_step;
    logic     mul;
    logic     check;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic first_pending;
    logic overflow_seen;
    logic last_task;
    logic gcd_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

[src/cefc_task_if.sv]
`timescale 1ns / 1ps
// Task channel: valid/ready handshake carrying one task per transaction.
// Depends on cefc_pkg for the field widths.
interface cefc_task_if;
  logic                       valid;
  logic                       ready;
  logic [cefc_pkg::PERIOD_BITS-1:0] task_period;
  logic [cefc_pkg::PERIOD_BITS-1:0] task_wcet;
  logic                       last_task;

  modport source (output valid, output task_period, output task_wcet, output last_task,
                  input ready);
  modport sink   (input valid, input task_period, input task_wcet, input last_task,
                  output ready);
endinterface

[src/cefc_result_if.sv]
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one task-set result per transaction.
// Depends on cefc_pkg for the field widths.
interface cefc_result_if;
  logic                             valid;
  logic                             ready;
  logic [cefc_pkg::HYPER_BITS-1:0]  hyperperiod;
  logic [cefc_pkg::PERIOD_BITS-1:0] minor_cycle;
  logic                             frame_ok;
  logic                             hyper_overflow;

  modport source (output valid, output hyperperiod, output minor_cycle, output frame_ok,
                  output hyper_overflow, input ready);
  modport sink   (input valid, input hyperperiod, input minor_cycle, input frame_ok,
                  input hyper_overflow, output ready);
endinterface

[src/cefc_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: sequences capture, GCD passes, division, multiply and
// the result load. Depends on cefc_pkg.
module cefc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              task_valid_i,
  output logic              task_ready_o,
  input  cefc_pkg::status_t status_i,
  output cefc_pkg::cmd_t    cmd_o
);

  cefc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cefc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cefc_pkg::ST_IDLE: begin
        if (task_valid_i) state_d = cefc_pkg::ST_START;
      end
      cefc_pkg::ST_START: begin
        state_d = status_i.first_pending ? cefc_pkg::ST_FINISH : cefc_pkg::ST_GCD_MINOR;
      end
      cefc_pkg::ST_GCD_MINOR: begin
        if (status_i.gcd_done) begin
          state_d = status_i.overflow_seen ? cefc_pkg::ST_FINISH : cefc_pkg::ST_GCD_LCM;
        end
      end
      cefc_pkg::ST_GCD_LCM: begin
        if (status_i.gcd_done) state_d = cefc_pkg::ST_DIV;
      end
      cefc_pkg::ST_DIV: begin
        if (status_i.div_done) state_d = cefc_pkg::ST_CHECK;
      end
      cefc_pkg::ST_CHECK: begin
        state_d = cefc_pkg::ST_FINISH;
      end
      cefc_pkg::ST_FINISH: begin
        if (!status_i.last_task || status_i.out_free) state_d = cefc_pkg::ST_IDLE;
      end
      default: begin
        state_d = cefc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    task_ready_o = 1'b0;
    case (state_q)
      cefc_pkg::ST_IDLE: begin
        task_ready_o  = 1'b1;
        cmd_o.capture = task_valid_i;
      end
      cefc_pkg::ST_START: begin
        if (status_i.first_pending) begin
          cmd_o.init_set = 1'b1;
        end else begin
          cmd_o.fold_wcet = 1'b1;
          cmd_o.gcd_start = 1'b1;
          cmd_o.gcd_src   = cefc_pkg::GCD_SRC_MINOR;
        end
      end
      cefc_pkg::ST_GCD_MINOR: begin
        if (!status_i.gcd_done) begin
          cmd_o.gcd_step = 1'b1;
        end else begin
          cmd_o.save_minor = 1'b1;
          cmd_o.gcd_start  = !status_i.overflow_seen;
          cmd_o.gcd_src    = cefc_pkg::GCD_SRC_LCM;
        end
      end
      cefc_pkg::ST_GCD_LCM: begin
        if (!status_i.gcd_done) begin
          cmd_o.gcd_step = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      cefc_pkg::ST_DIV: begin
        if (!status_i.div_done) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.mul = 1'b1;
        end
      end
      cefc_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
      end
      cefc_pkg::ST_FINISH: begin
        cmd_o.load_out = status_i.last_task && status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[src/cefc_dpath.sv]
`timescale 1ns / 1ps
// Datapath: task registers, running LCM/GCD/max, shared binary GCD unit, restoring
// divider, multiplier and the output register. Depends on cefc_pkg.
module cefc_dpath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cefc_pkg::cmd_t          cmd_i,
  output cefc_pkg::status_t       status_o,
  input  cefc_pkg::period_t       task_period_i,
  input  cefc_pkg::period_t       task_wcet_i,
  input  logic                    last_task_i,
  input  logic                    res_ready_i,
  output logic                    res_valid_o,
  output cefc_pkg::hyper_t        hyperperiod_o,
  output cefc_pkg::period_t       minor_cycle_o,
  output logic                    frame_ok_o,
  output logic                    hyper_overflow_o
);

  localparam int unsigned PB = cefc_pkg::PERIOD_BITS;
  localparam int unsigned HB = cefc_pkg::HYPER_BITS;

  // Captured task
  cefc_pkg::period_t per_q, wcet_q;
  logic              last_q;

  // Running set state
  cefc_pkg::hyper_t  lcm_q;
  cefc_pkg::period_t minor_q, wmax_q;
  logic              first_q, ovf_q;

  // Binary GCD unit
  cefc_pkg::hyper_t               ga_q, gb_q;
  logic [cefc_pkg::SHIFT_BITS-1:0] gk_q;
  cefc_pkg::hyper_t               gcd_res;
  logic                           gcd_done;

  // Restoring divider and product
  cefc_pkg::hyper_t                dq_q;
  cefc_pkg::period_t               dr_q, dd_q;
  logic [cefc_pkg::COUNT_BITS-1:0] dc_q;
  logic [PB:0]                     div_rs, div_sub;
  logic                            div_ge;
  logic [cefc_pkg::PROD_BITS-1:0]  prod_q;

  // Output register
  logic              ov_q;
  cefc_pkg::hyper_t  hyp_out_q;
  cefc_pkg::period_t minor_out_q;
  logic              ok_out_q, hov_out_q;
  logic              out_free;

  assign gcd_done = (ga_q == '0) || (gb_q == '0);
  assign gcd_res  = (ga_q | gb_q) << gk_q;

  assign div_rs  = {dr_q, dq_q[HB-1]};
  assign div_ge  = div_rs >= {1'b0, dd_q};
  assign div_sub = div_rs - {1'b0, dd_q};

  assign out_free = !ov_q || res_ready_i;

  assign status_o.first_pending = first_q;
  assign status_o.overflow_seen = ovf_q;
  assign status_o.last_task     = last_q;
  assign status_o.gcd_done      = gcd_done;
  assign status_o.div_done      = (dc_q == '0);
  assign status_o.out_free      = out_free;

  // Hold the task; a zero period counts as one
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      per_q  <= (task_period_i == '0) ? PB'(1) : task_period_i;
      wcet_q <= task_wcet_i;
      last_q <= last_task_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcm_q   <= '0;
      minor_q <= '0;
      wmax_q  <= '0;
      first_q <= 1'b1;
      ovf_q   <= 1'b0;
    end else begin
      if (cmd_i.init_set) begin
        lcm_q   <= HB'(per_q);
        minor_q <= per_q;
        wmax_q  <= wcet_q;
        ovf_q   <= 1'b0;
        first_q <= 1'b0;
      end
      if (cmd_i.fold_wcet && (wcet_q > wmax_q)) begin
        wmax_q <= wcet_q;
      end
      if (cmd_i.save_minor) begin
        minor_q <= gcd_res[PB-1:0];
      end
      if (cmd_i.check) begin
        if (prod_q[cefc_pkg::PROD_BITS-1:HB] != '0) begin
          lcm_q <= '1;
          ovf_q <= 1'b1;
        end else begin
          lcm_q <= prod_q[HB-1:0];
        end
      end
      if (cmd_i.load_out) begin
        first_q <= 1'b1;
      end
    end
  end

  // Binary GCD: strip common twos, strip single twos, halve the odd difference
  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_start) begin
      ga_q <= (cmd_i.gcd_src == cefc_pkg::GCD_SRC_MINOR) ? HB'(minor_q) : lcm_q;
      gb_q <= HB'(per_q);
      gk_q <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!ga_q[0] && !gb_q[0]) begin
        ga_q <= ga_q >> 1;
        gb_q <= gb_q >> 1;
        gk_q <= gk_q + 1'b1;
      end else if (!ga_q[0]) begin
        ga_q <= ga_q >> 1;
      end else if (!gb_q[0]) begin
        gb_q <= gb_q >> 1;
      end else if (ga_q >= gb_q) begin
        ga_q <= (ga_q - gb_q) >> 1;
      end else begin
        gb_q <= (gb_q - ga_q) >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q <= '0;
    end else if (cmd_i.div_start) begin
      dc_q <= cefc_pkg::COUNT_BITS'(HB);
    end else if (cmd_i.div_step) begin
      dc_q <= dc_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q <= lcm_q;
      dr_q <= '0;
      dd_q <= gcd_res[PB-1:0];
    end else if (cmd_i.div_step) begin
      dq_q <= {dq_q[HB-2:0], div_ge};
      dr_q <= div_ge ? div_sub[PB-1:0] : div_rs[PB-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= cefc_pkg::PROD_BITS'(dq_q) * cefc_pkg::PROD_BITS'(per_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      ov_q <= 1'b1;
    end else if (res_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      hyp_out_q   <= lcm_q;
      minor_out_q <= minor_q;
      ok_out_q    <= (minor_q >= wmax_q);
      hov_out_q   <= ovf_q;
    end
  end

  assign res_valid_o      = ov_q;
  assign hyperperiod_o    = hyp_out_q;
  assign minor_cycle_o    = minor_out_q;
  assign frame_ok_o       = ok_out_q;
  assign hyper_overflow_o = hov_out_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!ov_q || res_ready_i))
    else $error("result loaded over an untaken result");

  a_ovf_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (lcm_q == '1))
    else $error("overflow flagged without saturated hyperperiod");

  a_minor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_q |-> (minor_q != '0))
    else $error("minor cycle zero inside a task set");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dc_q != '0) |-> (dr_q < dd_q))
    else $error("divider remainder not below divisor");

endmodule

[src/cyclic_executive_frame_check.sv]
`timescale 1ns / 1ps
// Top level of the cyclic executive frame check: running hyperperiod (LCM),
// minor cycle (GCD) and frame test. Depends on cefc_pkg, both interfaces,
// cefc_ctrl and cefc_dpath.
//
//   port      dir  transaction
//   task_i    in   task_period, task_wcet, last_task
//   result_o  out  hyperperiod, minor_cycle, frame_ok, hyper_overflow
//
// The first task of a set only initialises the set; any later task runs the binary
// GCD unit (one step per cycle, two passes) and the 32-step restoring divider.
// Once the hyperperiod has saturated, a later task skips the second pass and the
// divider. One task is in work at a time.
// Reset clears the set state, so the next task opens a new set.
// A result waiting in the output register does not block new tasks; only the
// final task of the next set holds until that result is taken.
module cyclic_executive_frame_check (
  input  logic   clk_i,
  input  logic   rst_ni,
  cefc_task_if.sink     task_i,
  cefc_result_if.source result_o
);

  cefc_pkg::cmd_t    cmd;
  cefc_pkg::status_t status;
  logic              task_ready;

  assign task_i.ready = task_ready;

  cefc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .task_valid_i (task_i.valid),
    .task_ready_o (task_ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  cefc_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .task_period_i    (task_i.task_period),
    .task_wcet_i      (task_i.task_wcet),
    .last_task_i      (task_i.last_task),
    .res_ready_i      (result_o.ready),
    .res_valid_o      (result_o.valid),
    .hyperperiod_o    (result_o.hyperperiod),
    .minor_cycle_o    (result_o.minor_cycle),
    .frame_ok_o       (result_o.frame_ok),
    .hyper_overflow_o (result_o.hyper_overflow)
  );

endmodule
